>>> rtl/core/irdx_pkg.sv
// Shared constants, register indexes and the alphabet lookup for the
// integer to radix digits unit. No dependencies.
package irdx_pkg;

	localparam int VALUE_W        = 32;
	localparam int CHAR_W         = 8;
	localparam int DIGIT_W        = 4;
	localparam int RADIX_W        = 5;
	localparam int ALPHA_W        = 64;
	localparam int ALPHA_ENTRIES  = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 64;

	localparam int MAX_RADIX_DEF  = 16;
	localparam int VALUE_BITS_DEF = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

	localparam logic [RADIX_W-1:0] RADIX_RST    = 5'd10;
	localparam logic [ALPHA_W-1:0] ALPHA_LO_RST = 64'h3736_3534_3332_3130;
	localparam logic [ALPHA_W-1:0] ALPHA_HI_RST = 64'h0000_0000_0000_3938;

	// Character for one digit: digits 0 to 7 live in the low word, 8 to 15 in the high one.
	function automatic logic [CHAR_W-1:0] alpha_byte(input logic [ALPHA_W-1:0] lo,
			input logic [ALPHA_W-1:0] hi, input logic [DIGIT_W-1:0] d);
		logic [ALPHA_W-1:0] word;
		word = d[DIGIT_W-1] ? hi : lo;
		return word[d[DIGIT_W-2:0]*CHAR_W +: CHAR_W];
	endfunction

endpackage

>>> rtl/core/integer_to_radix_digits_unit.sv
// Top level of the integer to radix digits unit: configuration registers,
// sequencing, digit stack and output register. Depends on irdx_pkg,
// irdx_alpha_chk, irdx_div and irdx_ram.
//
// A request is taken when start is high and busy is low; the unit then writes
// the signed value's text in the configured radix, most significant character
// first, digits one per cycle, on char_out with char_valid high for exactly
// that cycle and last high on the final character. The receiver cannot stall
// the unit, so it must take every character in the cycle it appears. A
// negative value is led by a minus sign; the most negative value converts
// correctly. If the alphabet is invalid (radix below 2 or above MAX_RADIX, or
// an entry in use that is a zero byte, a plus or minus sign, or a repeat) the
// request is taken and produces no characters. Digits are found least
// significant first by a bit-serial divider that yields one quotient bit per
// cycle; the digits are pushed on a small RAM stack and then read back out one
// per cycle. The last character appears in the cycle in which busy falls, so a
// new request can be taken while it is on the ports. Configuration registers
// are written through cfg_we, cfg_index and cfg_data and must only be changed
// while busy is low.
module integer_to_radix_digits_unit #(
	parameter int MAX_RADIX  = irdx_pkg::MAX_RADIX_DEF,
	parameter int VALUE_BITS = irdx_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic signed [irdx_pkg::VALUE_W-1:0] value,
	output logic [irdx_pkg::CHAR_W-1:0]     char_out,
	output logic                            last,
	output logic                            char_valid,
	input  logic                            cfg_we,
	input  logic [irdx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [irdx_pkg::CFG_DATA_W-1:0] cfg_data
);
	import irdx_pkg::*;

	// Address width of the digit stack: radix 2 gives at most VALUE_BITS digits.
	localparam int AW = $clog2(VALUE_BITS);
	localparam int CW = $clog2(VALUE_BITS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SIGN = 2'd2;
	localparam logic [1:0] ST_READ = 2'd3;

	// Configuration registers.
	logic [RADIX_W-1:0] radix_q;
	logic [ALPHA_W-1:0] alpha_lo_q;
	logic [ALPHA_W-1:0] alpha_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q    <= RADIX_RST;
			alpha_lo_q <= ALPHA_LO_RST;
			alpha_hi_q <= ALPHA_HI_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RADIX:    radix_q    <= cfg_data[RADIX_W-1:0];
				CFG_ALPHA_LO: alpha_lo_q <= cfg_data[ALPHA_W-1:0];
				CFG_ALPHA_HI: alpha_hi_q <= cfg_data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	logic alpha_ok;

	irdx_alpha_chk #(
		.MAX_RADIX(MAX_RADIX)
	) u_chk (
		.radix   (radix_q),
		.alpha_lo(alpha_lo_q),
		.alpha_hi(alpha_hi_q),
		.ok      (alpha_ok)
	);

	// Sign and magnitude of the request, from the low VALUE_BITS bits.
	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic                  neg;

	assign raw = value[VALUE_BITS-1:0];
	assign neg = raw[VALUE_BITS-1];
	assign mag = neg ? ({VALUE_BITS{1'b0}} - raw) : raw;

	logic [1:0]            state_q;
	logic                  neg_q;
	logic [CW-1:0]         cnt_q;
	logic [AW-1:0]         ptr_q;
	logic                  s1_valid_s1;
	logic                  last_s1;
	logic                  accept;
	logic                  div_load;
	logic [VALUE_BITS-1:0] div_din;
	logic [VALUE_BITS-1:0] div_quot;
	logic [DIGIT_W-1:0]    div_rem;
	logic                  div_done;
	logic                  digit_wr;
	logic                  digits_end;
	logic                  rd_en;
	logic [DIGIT_W-1:0]    rd_digit;

	assign busy     = (state_q != ST_IDLE) || s1_valid_s1;
	assign accept   = start && !busy;
	assign digit_wr = (state_q == ST_DIV) && div_done;
	// The conversion ends once the quotient reaches zero.
	assign digits_end = div_quot == '0;
	assign div_load   = (accept && alpha_ok) || (digit_wr && !digits_end);
	assign div_din    = (state_q == ST_DIV) ? div_quot : mag;
	assign rd_en      = state_q == ST_READ;

	irdx_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.dividend (div_din),
		.radix    (radix_q),
		.quotient (div_quot),
		.remainder(div_rem),
		.done     (div_done)
	);

	// Digits arrive least significant first and are read back in reverse.
	irdx_ram #(
		.WIDTH(DIGIT_W),
		.DEPTH(VALUE_BITS)
	) u_stack (
		.clk  (clk),
		.we   (digit_wr),
		.waddr(cnt_q[AW-1:0]),
		.wdata(div_rem),
		.re   (rd_en),
		.raddr(ptr_q),
		.rdata(rd_digit)
	);

	// Sequencer: divide, optional sign, then read the stack top down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			neg_q       <= 1'b0;
			cnt_q       <= '0;
			ptr_q       <= '0;
			s1_valid_s1 <= 1'b0;
			last_s1     <= 1'b0;
		end else begin
			s1_valid_s1 <= rd_en;
			last_s1     <= rd_en && (ptr_q == '0);
			case (state_q)
				ST_IDLE: begin
					if (accept && alpha_ok) begin
						state_q <= ST_DIV;
						neg_q   <= neg;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (digit_wr) begin
						cnt_q <= cnt_q + CW'(1);
						if (digits_end) begin
							ptr_q   <= cnt_q[AW-1:0];
							state_q <= neg_q ? ST_SIGN : ST_READ;
						end
					end
				end
				ST_SIGN: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					if (ptr_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q - AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: the minus sign comes straight from the sequencer,
	// digits come from the stack's registered read data.
	logic              out_valid_q;
	logic              out_last_q;
	logic [CHAR_W-1:0] out_char_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			out_valid_q <= s1_valid_s1 || (state_q == ST_SIGN);
			out_last_q  <= s1_valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1) begin
			out_char_q <= alpha_byte(alpha_lo_q, alpha_hi_q, rd_digit);
		end else if (state_q == ST_SIGN) begin
			out_char_q <= CHAR_MINUS;
		end
	end

	assign char_out   = out_char_q;
	assign last       = out_last_q;
	assign char_valid = out_valid_q;

	// A finished division is only ever consumed by the divide state.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// No digit read may still be in flight when the final character leaves.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> !s1_valid_s1)
		else $error("last character flagged while digits remain");

	// The read pointer always stays inside the digits that were stored.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> ({1'b0, ptr_q} < {1'b0, cnt_q}))
		else $error("stack read beyond stored digits");

	// The digit count never passes the stack depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(VALUE_BITS))
		else $error("digit count overflow");

endmodule

>>> rtl/core/irdx_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module irdx_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/irdx_alpha_chk.sv
// Alphabet validity check: radix range, forbidden characters and duplicates.
// Depends on irdx_pkg.
module irdx_alpha_chk #(
	parameter int MAX_RADIX = irdx_pkg::MAX_RADIX_DEF
) (
	input  logic [irdx_pkg::RADIX_W-1:0] radix,
	input  logic [irdx_pkg::ALPHA_W-1:0] alpha_lo,
	input  logic [irdx_pkg::ALPHA_W-1:0] alpha_hi,
	output logic                         ok
);
	import irdx_pkg::*;

	logic [CHAR_W-1:0] ch [MAX_RADIX];
	logic              bad;

	always_comb begin
		for (int i = 0; i < MAX_RADIX; i++) begin
			ch[i] = alpha_byte(alpha_lo, alpha_hi, DIGIT_W'(i));
		end
	end

	// Every pair of entries in use is compared side by side.
	always_comb begin
		bad = (radix < RADIX_W'(2)) || (radix > RADIX_W'(MAX_RADIX));
		for (int i = 0; i < MAX_RADIX; i++) begin
			if (radix > RADIX_W'(i)) begin
				if (ch[i] == CHAR_NUL || ch[i] == CHAR_PLUS || ch[i] == CHAR_MINUS) begin
					bad = 1'b1;
				end
				for (int j = i + 1; j < MAX_RADIX; j++) begin
					if (radix > RADIX_W'(j) && ch[i] == ch[j]) begin
						bad = 1'b1;
					end
				end
			end
		end
	end

	assign ok = !bad;

endmodule

>>> rtl/core/irdx_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, narrow remainder.
// Depends on irdx_pkg.
module irdx_div #(
	parameter int VALUE_BITS = irdx_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  logic [VALUE_BITS-1:0]        dividend,
	input  logic [irdx_pkg::RADIX_W-1:0] radix,
	output logic [VALUE_BITS-1:0]        quotient,
	output logic [irdx_pkg::DIGIT_W-1:0] remainder,
	output logic                         done
);
	import irdx_pkg::*;

	localparam int BW = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] quo_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [BW-1:0]         bit_q;
	logic                  run_q;
	logic                  done_q;
	logic [RADIX_W-1:0]    trial;
	logic [RADIX_W-1:0]    diff;
	logic                  ge;

	// The remainder stays below the radix, so it and the next dividend bit fit in 5 bits.
	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign ge    = trial >= radix;
	assign diff  = trial - radix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else if (load) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else if (run_q) begin
			bit_q <= bit_q + BW'(1);
			if (bit_q == BW'(VALUE_BITS - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

>>> tb/irdx_text_checker.sv
`timescale 1ns / 1ps
// Checker for the integer to radix digits unit: tracks the register writes,
// predicts the text of every accepted request and compares the character
// stream. Depends on irdx_pkg.
module irdx_text_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [irdx_pkg::VALUE_W-1:0]   value,
	input  logic [irdx_pkg::CHAR_W-1:0]    char_out,
	input  logic                           last,
	input  logic                           char_valid,
	input  logic                           cfg_we,
	input  logic [irdx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [irdx_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             pending,
	output int                             chars_checked,
	output int                             requests_seen,
	output int                             silent_requests
);
	import irdx_pkg::*;

	localparam int REPORT_CAP = 100;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              fin;
	} text_char_t;

	text_char_t         char_queue[$];
	logic [RADIX_W-1:0] cur_radix;
	logic [ALPHA_W-1:0] cur_lo;
	logic [ALPHA_W-1:0] cur_hi;

	function automatic logic [CHAR_W-1:0] glyph_of(input int unsigned d);
		logic [2*ALPHA_W-1:0] glyph_row;
		glyph_row = {cur_hi, cur_lo};
		return glyph_row[d*CHAR_W +: CHAR_W];
	endfunction

	function automatic bit alphabet_usable();
		int unsigned i;
		int unsigned j;
		logic [CHAR_W-1:0] c;
		if (cur_radix < 2 || cur_radix > MAX_RADIX_DEF)
			return 1'b0;
		for (i = 0; i < cur_radix; i++) begin
			c = glyph_of(i);
			if (c == CHAR_NUL || c == CHAR_PLUS || c == CHAR_MINUS)
				return 1'b0;
			for (j = i + 1; j < cur_radix; j++)
				if (glyph_of(j) == c)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	// Queues the characters of one value's text; returns 0 when the alphabet
	// in use is not valid, in which case the unit stays silent.
	function automatic bit expand_text(input logic [VALUE_W-1:0] v);
		logic [VALUE_W-1:0] mag;
		int unsigned        digits[$];
		int unsigned        base;
		text_char_t         tc;
		if (!alphabet_usable())
			return 1'b0;
		base = 32'(cur_radix);
		mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
		do begin
			digits.push_front(mag % base);
			mag = mag / base;
		end while (mag != 0);
		if (v[VALUE_W-1]) begin
			tc.ch = CHAR_MINUS;
			tc.fin = 1'b0;
			char_queue.push_back(tc);
		end
		foreach (digits[k]) begin
			tc.ch = glyph_of(digits[k]);
			tc.fin = (k == digits.size() - 1);
			char_queue.push_back(tc);
		end
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string what, input logic [CHAR_W-1:0] want,
			input logic [CHAR_W-1:0] got);
		fail_count++;
		if (fail_count <= REPORT_CAP)
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		else if (fail_count == REPORT_CAP + 1)
			$display("%0t: further mismatches are counted but not shown", $time);
	endtask

	always @(posedge clk or negedge arst_n) begin
		text_char_t want;
		if (!arst_n) begin
			cur_radix = RADIX_RST;
			cur_lo = ALPHA_LO_RST;
			cur_hi = ALPHA_HI_RST;
			char_queue.delete();
			fail_count = 0;
			pending = 0;
			chars_checked = 0;
			requests_seen = 0;
			silent_requests = 0;
		end else begin
			if (char_valid) begin
				if (char_queue.size() == 0) begin
					report_mismatch("character with nothing pending", 'x, char_out);
				end else begin
					want = char_queue.pop_front();
					if (want.ch !== char_out)
						report_mismatch("char_out", want.ch, char_out);
					if (want.fin !== last)
						report_mismatch("last", want.fin, last);
					chars_checked++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_RADIX:    cur_radix = cfg_data[RADIX_W-1:0];
					CFG_ALPHA_LO: cur_lo = cfg_data;
					CFG_ALPHA_HI: cur_hi = cfg_data;
					default:      ;
				endcase
			end
			if (start && !busy) begin
				requests_seen++;
				if (!expand_text(value))
					silent_requests++;
			end
			pending = char_queue.size();
		end
	end

endmodule

>>> tb/tb_integer_to_radix_digits_unit.sv
`timescale 1ns / 1ps
// Testbench top for the integer to radix digits unit: clock, reset, register
// setup, request stimulus. Depends on irdx_pkg, the unit and irdx_text_checker.
module tb_integer_to_radix_digits_unit;
	import irdx_pkg::*;

	// Number of random requests under valid alphabets before the run winds down.
	localparam int ITEM_TARGET = 380;
	// Percentage of requests that are preceded by an idle stretch on start.
	localparam int GAP_PCT = 35;
	// Pause before a register write or the verdict. An invalid alphabet yields no
	// characters, so an empty expectation queue alone does not prove the unit idle.
	localparam int SETTLE_CYCLES = 64;
	// The slowest legal request is the most negative value in radix 2: 32 digits
	// plus the minus sign. About 420 requests with the longest idle gap in front
	// of each stay well under the limit, so the limit leaves a wide margin.
	localparam longint LIMIT_CYCLES = 2_500_000;
	// Index 3 maps to no register and must be ignored by the unit.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [VALUE_W-1:0]    value = '0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  busy;
	logic [CHAR_W-1:0]     char_out;
	logic                  last;
	logic                  char_valid;

	int          fail_count;
	int          pending;
	int          chars_checked;
	int          requests_seen;
	int          silent_requests;
	int          gap_pct = GAP_PCT;
	int unsigned active_radix;
	int          settings_tried = 0;
	longint      cycle_count = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	integer_to_radix_digits_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.char_out   (char_out),
		.last       (last),
		.char_valid (char_valid),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// The checker sees the same pins as the unit and does all prediction and
	// comparison; this module only produces stimulus and reads its counters.
	irdx_text_checker text_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.value           (value),
		.char_out        (char_out),
		.last            (last),
		.char_valid      (char_valid),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.chars_checked   (chars_checked),
		.requests_seen   (requests_seen),
		.silent_requests (silent_requests)
	);

	// Drives one register write and waits for the edge that takes it. The write
	// enable stays high so that back-to-back writes never lower and raise it
	// within one step; the caller drops it when the sequence is done.
	task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Writes all three registers, optionally also the unused index with junk.
	task automatic load_alphabet(input logic [CFG_DATA_W-1:0] radix_word,
			input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
			input bit with_spare);
		if (with_spare)
			set_register(CFG_SPARE, {$urandom, $urandom});
		set_register(CFG_RADIX, radix_word);
		set_register(CFG_ALPHA_LO, lo);
		set_register(CFG_ALPHA_HI, hi);
		cfg_we <= 1'b0;
		active_radix = 32'(radix_word[RADIX_W-1:0]);
		settings_tried++;
	endtask

	// Waits until every predicted character has come out and the unit has gone
	// quiet. Sampling happens on the falling edge so that the checker's counters
	// are settled; the task returns on a rising edge, ready to drive again.
	task automatic settle();
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
		while (busy)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Issues one request and returns at the edge that takes it. Sometimes start
	// idles first, with junk on value, so that idle time lands both while the
	// unit is still busy and after it has finished.
	task automatic request_text(input logic [VALUE_W-1:0] v);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			value <= $urandom;
			repeat ($urandom_range(1, 40))
				@(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Picks a value that stresses the current radix: raw random words, short
	// magnitudes, the radix itself, powers of the radix and their neighbors
	// (where the digit count changes), and the range ends.
	function automatic logic [VALUE_W-1:0] pick_value(input int unsigned base);
		logic [VALUE_W-1:0] v;
		longint unsigned    p;
		int unsigned        k;
		case ($urandom_range(6))
			0: v = $urandom;
			1: v = $urandom >> $urandom_range(31);
			2: v = $urandom_range(3 * base);
			3: v = base;
			4: begin
				p = 1;
				k = $urandom_range(1, 31);
				repeat (k)
					if (p * base <= 64'h8000_0000)
						p = p * base;
				v = VALUE_W'(p + $urandom_range(2) - 1);
			end
			5: begin
				case ($urandom_range(3))
					0:       v = 32'h8000_0000;
					1:       v = 32'h7FFF_FFFF;
					2:       v = '0;
					default: v = '1;
				endcase
			end
			default: v = $urandom;
		endcase
		if ($urandom_range(1))
			v = -v;
		return v;
	endfunction

	// Builds a random alphabet of distinct usable characters for the radix in
	// use. Entries past the radix get any byte at all, since the unit must not
	// look at them. A spoiled setting breaks one entry or the radix itself.
	task automatic random_setting(input bit spoil);
		logic [CHAR_W-1:0]     glyph[ALPHA_ENTRIES];
		bit                    taken[256];
		logic [CFG_DATA_W-1:0] radix_word;
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		logic [CHAR_W-1:0]     b;
		int unsigned           base;
		int unsigned           i;
		int unsigned           victim;
		case ($urandom_range(3))
			0:       base = 2;
			1:       base = MAX_RADIX_DEF;
			default: base = $urandom_range(2, MAX_RADIX_DEF);
		endcase
		for (i = 0; i < ALPHA_ENTRIES; i++) begin
			if (i < base) begin
				do
					b = CHAR_W'($urandom_range(255));
				while (b == CHAR_NUL || b == CHAR_PLUS || b == CHAR_MINUS || taken[b]);
				taken[b] = 1'b1;
			end else begin
				b = CHAR_W'($urandom_range(255));
			end
			glyph[i] = b;
		end
		radix_word = {$urandom, $urandom};
		radix_word[RADIX_W-1:0] = RADIX_W'(base);
		if (spoil) begin
			victim = $urandom_range(base - 1);
			case ($urandom_range(4))
				0: glyph[victim] = CHAR_NUL;
				1: glyph[victim] = CHAR_PLUS;
				2: glyph[victim] = CHAR_MINUS;
				3: glyph[victim] = glyph[(victim + 1) % base];
				default: radix_word[RADIX_W-1:0] = RADIX_W'($urandom_range(1)
						? $urandom_range(1) : $urandom_range(MAX_RADIX_DEF + 1, 31));
			endcase
		end
		for (i = 0; i < ALPHA_ENTRIES; i++) begin
			if (i < 8)
				lo[i*CHAR_W +: CHAR_W] = glyph[i];
			else
				hi[(i-8)*CHAR_W +: CHAR_W] = glyph[i];
		end
		load_alphabet(radix_word, lo, hi, $urandom_range(1));
	endtask

	// Watchdog: a hung unit or a lost character ends the run here.
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped at the cycle limit with %0d characters outstanding.", pending);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int valid_sent;
		int phase;
		int n;
		bit spoil;

		valid_sent = 0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Decimal alphabet from reset: zero, unit values, 9, the radix and minus the
		// radix, and both ends of the range including the most negative one.
		active_radix = 32'(RADIX_RST);
		request_text(32'd0);
		request_text(32'd1);
		request_text(-32'sd1);
		request_text(32'd9);
		request_text(32'd10);
		request_text(-32'sd10);
		request_text(32'h7FFF_FFFF);
		request_text(32'h8000_0000);
		settle();

		// Binary gives the longest text: a minus sign and 32 digits. The unused
		// entries hold signs and zero bytes, which must not matter.
		load_alphabet(64'd2, 64'h2B2D_0000_FFFF_3130, '1, 1'b0);
		request_text(32'h8000_0000);
		request_text(32'h7FFF_FFFF);
		request_text(-32'sd2);
		settle();

		// Full sixteen-entry alphabet; the radix write carries all-ones upper
		// bits, and the unused index is written as well.
		load_alphabet(64'hFFFF_FFFF_FFFF_FFF0, 64'h3736_3534_3332_3130,
				64'h4645_4443_4241_3938, 1'b1);
		request_text(-32'sd16);
		request_text(32'hDEAD_BEEF);
		request_text(32'h0000_000F);
		settle();

		// Invalid alphabets: every request is taken and no character may appear.
		load_alphabet(64'h0, ALPHA_LO_RST, ALPHA_HI_RST, 1'b0);
		request_text(-32'sd5);
		settle();
		load_alphabet(64'd1, ALPHA_LO_RST, ALPHA_HI_RST, 1'b0);
		request_text(32'd7);
		settle();
		load_alphabet(64'd17, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 1'b0);
		request_text(32'd123);
		settle();
		load_alphabet('1, 64'h3736_3534_3332_3130, 64'h4645_4443_4241_3938, 1'b0);
		request_text(-32'sd1);
		settle();
		// A plus sign, a minus sign, zero bytes and repeated entries in use.
		load_alphabet(64'd3, 64'h32_2B30, ALPHA_HI_RST, 1'b0);
		request_text(32'd5);
		settle();
		load_alphabet(64'd3, 64'h2D_3130, ALPHA_HI_RST, 1'b0);
		request_text(-32'sd4);
		settle();
		load_alphabet(64'd4, 64'h0, 64'h0, 1'b0);
		request_text(32'd3);
		settle();
		load_alphabet(64'd2, '1, '1, 1'b0);
		request_text(32'd1);
		settle();

		// Random phases: a fresh alphabet each time, now and then a spoiled one
		// with only a few requests, and a third phase, long unless spoiled, with no idle time on start.
		phase = 0;
		while (valid_sent < ITEM_TARGET) begin
			spoil = (phase > 0) && ($urandom_range(9) == 0);
			random_setting(spoil);
			gap_pct = (phase == 2) ? 0 : GAP_PCT;
			if (spoil)
				n = $urandom_range(1, 3);
			else if (phase == 2)
				n = 60;
			else
				n = $urandom_range(15, 40);
			repeat (n)
				request_text(pick_value(active_radix));
			if (!spoil)
				valid_sent += n;
			settle();
			phase++;
		end

		$display("Issued %0d requests over %0d register settings, %0d of them silent.",
				requests_seen, settings_tried, silent_requests);
		$display("Compared %0d characters; %0d mismatches.", chars_checked, fail_count);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
